// ----- rtl/position_cost_pnl_tracker_defines.svh -----
// ----------------------------------------------------------------------------
// Position cost / PnL tracker assertion macros
// Shared concurrent assertion shorthands, sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef POSITION_COST_PNL_TRACKER_DEFINES_SVH
`define POSITION_COST_PNL_TRACKER_DEFINES_SVH

// same-cycle implication
`define PCPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pcpt_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpt_pkg
// Types, widths and saturation helpers for the position cost / PnL tracker.
// ----------------------------------------------------------------------------
package pcpt_pkg;

  localparam int SYM_W      = 8;
  localparam int QTY_W      = 31;
  localparam int PX_W       = 32;
  localparam int NET_W      = 48;
  localparam int PNL_W      = 64;
  localparam int ACC_W      = 80;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 216;

  localparam logic [PNL_W-1:0] PNL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [PNL_W-1:0] PNL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [NET_W-1:0] NET_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [NET_W-1:0] NET_MIN = 48'h8000_0000_0000;

  // classified input beat
  typedef struct packed {
    logic             op;
    logic [SYM_W-1:0] sym;
    logic             side;
    logic [QTY_W-1:0] qty;
    logic [PX_W-1:0]  px;
    logic [PX_W-1:0]  fee;
    logic             in_range;
  } pcpt_item_t;

  // one position table row
  typedef struct packed {
    logic [NET_W-1:0] net;
    logic [PX_W-1:0]  cost;
    logic [PNL_W-1:0] booked;
    logic [PNL_W-1:0] open_pnl;
    logic [PX_W-1:0]  mark;
  } pcpt_entry_t;

  // back-end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic idle;
  } pcpt_stat_t;

  function automatic logic [PNL_W-1:0] sat_add64(input logic [PNL_W-1:0] a,
                                                 input logic [PNL_W-1:0] b);
    logic [PNL_W:0] s;
    s = {a[PNL_W-1], a} + {b[PNL_W-1], b};
    if (s[PNL_W] != s[PNL_W-1]) begin
      return s[PNL_W] ? PNL_MIN : PNL_MAX;
    end
    return s[PNL_W-1:0];
  endfunction

  function automatic logic [NET_W-1:0] sat_net(input logic [NET_W:0] s);
    if (s[NET_W] != s[NET_W-1]) begin
      return s[NET_W] ? NET_MIN : NET_MAX;
    end
    return s[NET_W-1:0];
  endfunction

endpackage

// ----- rtl/position_cost_pnl_tracker.sv -----
// ----------------------------------------------------------------------------
// position_cost_pnl_tracker
// Per-symbol average-cost position and PnL table driven by fill/mark beats.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                               | tuser
//  in_     | in  | symbol_index, side, fill_quantity, price, fee    | op
//  out_    | out | out_symbol, net_pos, avg_cost,                   | -
//          |     | booked_pnl, open_pnl                             |
//
//  Per beat: marks and reducing fills use the shared 32x32 multiplier passes;
//  extending fills also use the 32-step radix-2 divider after those passes.
//  One beat is worked at a time in the back end.
//  Reset: synchronous, active low; then a clearing pass zeroes all
//  min(NUM_SYMBOLS, 256) table rows, in_tready low throughout.
//  Stalls: a two-beat queue parts input from the back end; a held result sits
//  in the output register, the next finished result waits in the done step.
// ----------------------------------------------------------------------------
`include "position_cost_pnl_tracker_defines.svh"

module position_cost_pnl_tracker #(
  parameter int NUM_SYMBOLS = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // symbol_index[7:0], side[8], fill_quantity[39:9], price[71:40], fee[103:72]
  input  logic [103:0]  in_tdata,
  // op[0]: 0 fill, 1 mark
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // out_symbol[7:0], net_pos[55:8], avg_cost[87:56],
  // booked_pnl[151:88], open_pnl[215:152]
  output logic [215:0]  out_tdata
);

  pcpt_pkg::pcpt_stat_t st;
  pcpt_pkg::pcpt_item_t q_item;
  logic                 q_valid, q_pop;

  // front: accepts and classifies beats into the queue
  pcpt_front #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .st        (st),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back: table update, arithmetic and result register
  pcpt_back #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // no beat taken while the table is being cleared
  `PCPT_ASSERT_NOW(a_clr_blocks_in, st.clearing, !in_tready, "beat accepted during clear")
  // back end pops only an occupied queue, and only from idle
  `PCPT_ASSERT_NOW(a_pop_ok, q_pop, q_valid && st.idle, "pop from empty queue or busy")
  // one item at a time: never two pops in a row
  `PCPT_ASSERT_NEXT(a_pop_gap, q_pop, !q_pop, "back-to-back pop")

endmodule

// ----- rtl/pcpt_front.sv -----
// ----------------------------------------------------------------------------
// pcpt_front
// Input side: takes beats, flags out-of-range symbols, two-entry queue.
// ----------------------------------------------------------------------------
module pcpt_front #(
  parameter int NUM_SYMBOLS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pcpt_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  pcpt_pkg::pcpt_stat_t                st,
  output logic                                q_valid,
  output pcpt_pkg::pcpt_item_t                q_item,
  input  logic                                q_pop
);

  pcpt_pkg::pcpt_item_t fifo_r [0:1];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [1:0]           cnt_r;
  pcpt_pkg::pcpt_item_t new_item;
  logic                 push;

  always_comb begin
    new_item.op       = in_tuser;
    new_item.sym      = in_tdata[7:0];
    new_item.side     = in_tdata[8];
    new_item.qty      = in_tdata[39:9];
    new_item.px       = in_tdata[71:40];
    new_item.fee      = in_tdata[103:72];
    new_item.in_range = ({24'd0, in_tdata[7:0]} < 32'(NUM_SYMBOLS));
  end

  assign in_tready = (cnt_r != 2'd2) && !st.clearing;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/pcpt_back.sv -----
// ----------------------------------------------------------------------------
// pcpt_back
// Execution side: table memory, shared multiplier, radix-2 divider,
// saturating accumulate and output register.
// ----------------------------------------------------------------------------
module pcpt_back #(
  parameter int NUM_SYMBOLS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  pcpt_pkg::pcpt_item_t                q_item,
  output logic                                q_pop,
  output pcpt_pkg::pcpt_stat_t                st,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pcpt_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int DEPTH = (NUM_SYMBOLS < 256) ? NUM_SYMBOLS : 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [10:0] {
    ST_CLR  = 11'b000_0000_0001,
    ST_IDLE = 11'b000_0000_0010,
    ST_LD   = 11'b000_0000_0100,
    ST_MUL  = 11'b000_0000_1000,
    ST_DSET = 11'b000_0001_0000,
    ST_DIV  = 11'b000_0010_0000,
    ST_BOOK = 11'b000_0100_0000,
    ST_FIN  = 11'b000_1000_0000,
    ST_OPS  = 11'b001_0000_0000,
    ST_SAT  = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    JOB_AVG  = 2'd0,
    JOB_BOOK = 2'd1,
    JOB_OPEN = 2'd2
  } job_t;

  state_t state_r, state_nxt;

  // table memory
  pcpt_pkg::pcpt_entry_t mem [0:DEPTH-1];
  pcpt_pkg::pcpt_entry_t rdata_r, mem_wd;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa, clr_r;

  // working registers
  pcpt_pkg::pcpt_item_t  cur_r;
  logic [47:0]           old_r, net_r, opx_r, d_r, rem_r;
  logic [31:0]           cost_r, mark_r, opy_r, dvd_r;
  logic [63:0]           booked_r, open_r, p_r;
  logic [79:0]           acc_r;
  logic                  neg_r, flip_r, flat_r, psh_r, pv_r;
  job_t                  job_r;
  logic [4:0]            cnt_r;
  logic                  out_valid_r;
  logic [pcpt_pkg::OUT_DATA_W-1:0] out_data_r;

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // load-stage derivations
  logic [47:0] ld_old, ld_oq, ld_q48, ld_dsum;
  logic        ld_neg, ld_ext;
  logic [30:0] ld_close;
  logic [32:0] ld_d2, ld_d2m;
  always_comb begin
    ld_old  = rdata_r.net;
    ld_neg  = ld_old[47];
    ld_oq   = ld_neg ? (48'd0 - ld_old) : ld_old;
    ld_q48  = {17'd0, cur_r.qty};
    ld_ext  = (ld_old == 48'd0) || ((cur_r.qty != 31'd0) && (ld_neg == cur_r.side));
    ld_dsum = ld_oq + ld_q48;
    ld_close = (ld_oq < ld_q48) ? ld_oq[30:0] : cur_r.qty;
    ld_d2   = ld_neg ? ({1'b0, rdata_r.cost} - {1'b0, cur_r.px})
                     : ({1'b0, cur_r.px} - {1'b0, rdata_r.cost});
    ld_d2m  = ld_d2[32] ? (33'd0 - ld_d2) : ld_d2;
  end

  // finish / open-pnl derivations
  logic [48:0] fin_sq, fin_sum;
  logic [63:0] fee_neg, book_v, sat_v;
  logic [32:0] od, odm;
  logic [47:0] onm;
  logic        big;
  always_comb begin
    fin_sq  = cur_r.side ? (49'd0 - {18'd0, cur_r.qty}) : {18'd0, cur_r.qty};
    fin_sum = {old_r[47], old_r} + fin_sq;
    fee_neg = 64'd0 - {32'd0, cur_r.fee};
    book_v  = neg_r ? (64'd0 - acc_r[63:0]) : acc_r[63:0];
    od      = {1'b0, mark_r} - {1'b0, cost_r};
    odm     = od[32] ? (33'd0 - od) : od;
    onm     = net_r[47] ? (48'd0 - net_r) : net_r;
    big     = (acc_r[79:63] != 17'd0);
    if (neg_r) sat_v = big ? pcpt_pkg::PNL_MIN : (64'd0 - acc_r[63:0]);
    else       sat_v = big ? pcpt_pkg::PNL_MAX : acc_r[63:0];
  end

  // multiplier operand sequencing
  logic [31:0] mul_a, mul_b;
  logic        mul_sh;
  logic [4:0]  nops;
  always_comb begin
    mul_a  = opx_r[31:0];
    mul_b  = opy_r;
    mul_sh = 1'b0;
    nops   = 5'd1;
    unique case (job_r)
      JOB_AVG: begin
        nops  = 5'd3;
        mul_b = cost_r;
        if (cnt_r == 5'd1) begin
          mul_a  = {16'd0, opx_r[47:32]};
          mul_sh = 1'b1;
        end else if (cnt_r == 5'd2) begin
          mul_a = {1'b0, cur_r.qty};
          mul_b = cur_r.px;
        end
      end
      JOB_BOOK: nops = 5'd1;
      JOB_OPEN: begin
        nops = 5'd2;
        if (cnt_r == 5'd1) begin
          mul_a  = {16'd0, opx_r[47:32]};
          mul_sh = 1'b1;
        end
      end
      default: nops = 5'd1;
    endcase
  end

  // divider step
  logic [48:0] dv_trial, dv_diff;
  logic        dv_ge;
  always_comb begin
    dv_trial = {rem_r, dvd_r[31]};
    dv_diff  = dv_trial - {1'b0, d_r};
    dv_ge    = (dv_trial >= {1'b0, d_r});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_r == IDX_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (q_valid) state_nxt = ST_LD;
      ST_LD: begin
        if (!cur_r.in_range)            state_nxt = ST_DONE;
        else if (cur_r.op)              state_nxt = ST_OPS;
        else if (ld_ext && ld_dsum == 48'd0) state_nxt = ST_FIN;
        else                            state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_r == nops) begin
          unique case (job_r)
            JOB_AVG:  state_nxt = ST_DSET;
            JOB_BOOK: state_nxt = ST_BOOK;
            default:  state_nxt = ST_SAT;
          endcase
        end
      end
      ST_DSET: state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'd31) state_nxt = ST_FIN;
      ST_BOOK: state_nxt = ST_FIN;
      ST_FIN:  state_nxt = (mark_r != 32'd0) ? ST_OPS : ST_DONE;
      ST_OPS:  state_nxt = ST_MUL;
      ST_SAT:  state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign q_pop       = (state_r == ST_IDLE) && q_valid;
  assign st.clearing = (state_r == ST_CLR);
  assign st.idle     = (state_r == ST_IDLE);

  // memory port
  always_comb begin
    mem_we = (state_r == ST_CLR) ||
             ((state_r == ST_DONE) && out_free && cur_r.in_range);
    mem_wa = (state_r == ST_CLR) ? clr_r : cur_r.sym[IDX_W-1:0];
    mem_wd = '0;
    if (state_r != ST_CLR) begin
      mem_wd.net      = net_r;
      mem_wd.cost     = cost_r;
      mem_wd.booked   = booked_r;
      mem_wd.open_pnl = open_r;
      mem_wd.mark     = mark_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[q_item.sym[IDX_W-1:0]];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + IDX_W'(1);
      if ((state_r == ST_DONE) && out_free) out_valid_r <= 1'b1;
      else if (out_tready)                  out_valid_r <= 1'b0;
    end
  end

  // product valid: registered with each multiplier pass, flags when p_r holds that product
  always_ff @(posedge clk) begin
    pv_r <= (state_r == ST_MUL) && (cnt_r < nops);
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cur_r <= q_item;
      end
      ST_LD: begin
        old_r    <= ld_old;
        net_r    <= ld_old;
        cost_r   <= rdata_r.cost;
        booked_r <= rdata_r.booked;
        open_r   <= rdata_r.open_pnl;
        mark_r   <= cur_r.op ? cur_r.px : rdata_r.mark;
        acc_r    <= '0;
        cnt_r    <= '0;
        flip_r   <= (ld_q48 > ld_oq);
        flat_r   <= (ld_oq == ld_q48);
        d_r      <= ld_dsum;
        if (ld_ext) begin
          job_r <= JOB_AVG;
          opx_r <= ld_oq;
        end else begin
          job_r <= JOB_BOOK;
          opx_r <= {17'd0, ld_close};
          opy_r <= ld_d2m[31:0];
          neg_r <= ld_d2[32];
        end
      end
      ST_MUL: begin
        if (cnt_r < nops) begin
          p_r   <= mul_a * mul_b;
          psh_r <= mul_sh;
        end
        if (pv_r) acc_r <= acc_r + (psh_r ? {p_r[47:0], 32'd0} : {16'd0, p_r});
        cnt_r <= cnt_r + 5'd1;
      end
      ST_DSET: begin
        rem_r <= acc_r[79:32];
        dvd_r <= acc_r[31:0];
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= dv_ge ? dv_diff[47:0] : dv_trial[47:0];
        dvd_r <= {dvd_r[30:0], dv_ge};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) cost_r <= {dvd_r[30:0], dv_ge};
      end
      ST_BOOK: begin
        booked_r <= pcpt_pkg::sat_add64(booked_r, book_v);
        if (flat_r)      cost_r <= 32'd0;
        else if (flip_r) cost_r <= cur_r.px;
      end
      ST_FIN: begin
        net_r    <= pcpt_pkg::sat_net(fin_sum);
        booked_r <= pcpt_pkg::sat_add64(booked_r, fee_neg);
      end
      ST_OPS: begin
        job_r <= JOB_OPEN;
        opx_r <= onm;
        opy_r <= odm[31:0];
        neg_r <= od[32] ^ net_r[47];
        acc_r <= '0;
        cnt_r <= '0;
      end
      ST_SAT: begin
        open_r <= sat_v;
      end
      ST_DONE: begin
        if (out_free) begin
          if (cur_r.in_range) out_data_r <= {open_r, booked_r, cost_r, net_r, cur_r.sym};
          else                out_data_r <= {208'd0, cur_r.sym};
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
